// ===== rtl/pcm_pkg.sv =====
// pcm_pkg: shared types and constants for the pixel color matrix block
// used by pcm_lane, pcm_merge and pixel_color_matrix_top
package pcm_pkg;

  localparam int unsigned NumCh   = 4;
  localparam int unsigned ChW     = 8;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned FracW   = 12;
  localparam int unsigned RowW    = NumCh * CoefW;
  // 9-bit signed pixel times 16-bit signed coefficient fits in 24 bits
  localparam int unsigned ProdW   = 24;
  // four products summed
  localparam int unsigned SumW    = ProdW + 2;
  localparam int unsigned ModeW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 64;

  typedef enum logic [ModeW-1:0] {
    ModePass = 2'd0,
    ModeMat3 = 2'd1,
    ModeMat4 = 2'd2
  } mode_e;

  localparam logic [CfgIdxW-1:0] CfgMode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRow0 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRow1 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRow2 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgRow3 = 3'd4;

  // identity matrix rows, 1.0 in Q4.12 on the diagonal
  localparam logic [RowW-1:0] RowRst0 = 64'h0000_0000_0000_1000;
  localparam logic [RowW-1:0] RowRst1 = 64'h0000_0000_1000_0000;
  localparam logic [RowW-1:0] RowRst2 = 64'h0000_1000_0000_0000;
  localparam logic [RowW-1:0] RowRst3 = 64'h1000_0000_0000_0000;

  typedef logic [ChW-1:0] byte_t;

  typedef struct packed {
    byte_t [NumCh-1:0] ch;
    logic              last;
  } pix_t;

  // pipeline control for the merge stage
  typedef struct packed {
    logic              en;
    logic [ModeW-1:0]  mode;
  } ctl_t;

endpackage

// ===== rtl/pcm_lane.sv =====
// pcm_lane: one output channel of the color matrix
// multiply stage then sum, floor and saturate stage; uses pcm_pkg
module pcm_lane (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  pcm_pkg::byte_t [pcm_pkg::NumCh-1:0] ch_i,
  input  logic                          use_ch3_i,
  input  logic [pcm_pkg::RowW-1:0]      row_i,
  output pcm_pkg::byte_t                res_o
);

  logic signed [pcm_pkg::ProdW-1:0] prod_d [pcm_pkg::NumCh];
  logic signed [pcm_pkg::ProdW-1:0] prod_q [pcm_pkg::NumCh];
  logic signed [pcm_pkg::SumW-1:0]  sum;
  logic [pcm_pkg::SumW-pcm_pkg::FracW-1:0] int_part;
  pcm_pkg::byte_t res_d, res_q;
  pcm_pkg::byte_t ch_m [pcm_pkg::NumCh];

  always_comb begin
    for (int c = 0; c < pcm_pkg::NumCh; c++) begin
      ch_m[c] = ch_i[c];
    end
    // three-channel mode drops column 3
    if (!use_ch3_i) begin
      ch_m[pcm_pkg::NumCh-1] = '0;
    end
    // both operands widened to the product width before the multiply
    for (int c = 0; c < pcm_pkg::NumCh; c++) begin
      prod_d[c] = $signed({{(pcm_pkg::ProdW-pcm_pkg::ChW){1'b0}}, ch_m[c]})
                * $signed({{(pcm_pkg::ProdW-pcm_pkg::CoefW)
                             {row_i[c*pcm_pkg::CoefW+pcm_pkg::CoefW-1]}},
                           row_i[c*pcm_pkg::CoefW +: pcm_pkg::CoefW]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < pcm_pkg::NumCh; c++) begin
        prod_q[c] <= prod_d[c];
      end
    end
  end

  always_comb begin
    sum = pcm_pkg::SumW'(prod_q[0]) + pcm_pkg::SumW'(prod_q[1])
        + pcm_pkg::SumW'(prod_q[2]) + pcm_pkg::SumW'(prod_q[3]);
    int_part = sum[pcm_pkg::SumW-1:pcm_pkg::FracW];
    if (sum[pcm_pkg::SumW-1]) begin
      res_d = '0;
    end else if (int_part > (pcm_pkg::SumW-pcm_pkg::FracW)'(255)) begin
      res_d = '1;
    end else begin
      res_d = int_part[pcm_pkg::ChW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/pcm_merge.sv =====
// pcm_merge: picks lane results or delayed input bytes per mode
// and holds the output register; uses pcm_pkg
module pcm_merge (
  input  logic                                clk_i,
  input  pcm_pkg::ctl_t                       ctl_i,
  input  pcm_pkg::byte_t [pcm_pkg::NumCh-1:0] lane_i,
  input  pcm_pkg::pix_t                       pix_i,
  output pcm_pkg::pix_t                       pix_o
);

  pcm_pkg::pix_t pix_d, pix_q;

  always_comb begin
    pix_d = pix_i;
    case (pcm_pkg::mode_e'(ctl_i.mode))
      pcm_pkg::ModeMat3: begin
        for (int c = 0; c < pcm_pkg::NumCh - 1; c++) begin
          pix_d.ch[c] = lane_i[c];
        end
      end
      pcm_pkg::ModeMat4: begin
        pix_d.ch = lane_i;
      end
      default: begin
        pix_d = pix_i;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o = pix_q;

endmodule

// ===== rtl/pixel_color_matrix_top.sv =====
// pixel_color_matrix_top: per-pixel 4x4 color matrix, four lanes and a merge stage
// depends on pcm_pkg, pcm_lane, pcm_merge
//
// Input beats carry one pixel of four bytes plus a last flag on in_valid_i /
// in_stall_o; result beats leave on out_valid_o / out_stall_i with the same
// fields. Three register stages: products register, sum and saturate
// register, output register. out_valid_o comes from a valid bit that moves
// with the pixel through the same three registers. Throughput is one pixel
// per clock while the receiver does not stall; each output channel has its
// own multiply-add lane. When the receiver stalls with a result waiting, the
// whole pipeline holds and in_stall_o rises in the same cycle; a result
// waiting alone still lets new pixels enter while out_stall_i is low. The
// config port writes mode (index 0) and the four coefficient rows (1..4);
// the user must write them only while idle, which the block does not
// enforce. Writes to other indexes are dropped. Reset empties the pipeline,
// sets mode to pass-through and loads the identity matrix.
module pixel_color_matrix_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pcm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [pcm_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [7:0]                      in_ch0_i,
  input  logic [7:0]                      in_ch1_i,
  input  logic [7:0]                      in_ch2_i,
  input  logic [7:0]                      in_ch3_i,
  input  logic                            in_last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_ch0_o,
  output logic [7:0]                      out_ch1_o,
  output logic [7:0]                      out_ch2_o,
  output logic [7:0]                      out_ch3_o,
  output logic                            out_last_o
);

  logic [pcm_pkg::ModeW-1:0] mode_q;
  logic [pcm_pkg::RowW-1:0]  row_q [pcm_pkg::NumCh];
  logic [2:0]                vld_q;
  logic                      en;
  logic                      use_ch3;
  pcm_pkg::ctl_t             ctl;
  pcm_pkg::pix_t             pix_in, pix_s1_q, pix_s2_q, pix_out;
  pcm_pkg::byte_t [pcm_pkg::NumCh-1:0] lane_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pcm_pkg::ModePass;
      row_q[0] <= pcm_pkg::RowRst0;
      row_q[1] <= pcm_pkg::RowRst1;
      row_q[2] <= pcm_pkg::RowRst2;
      row_q[3] <= pcm_pkg::RowRst3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pcm_pkg::CfgMode: mode_q   <= cfg_data_i[pcm_pkg::ModeW-1:0];
        pcm_pkg::CfgRow0: row_q[0] <= cfg_data_i;
        pcm_pkg::CfgRow1: row_q[1] <= cfg_data_i;
        pcm_pkg::CfgRow2: row_q[2] <= cfg_data_i;
        pcm_pkg::CfgRow3: row_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline moves whenever the output slot is free or being taken
  assign en         = !vld_q[2] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], in_valid_i};
    end
  end

  assign pix_in.ch   = {in_ch3_i, in_ch2_i, in_ch1_i, in_ch0_i};
  assign pix_in.last = in_last_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pix_s1_q <= pix_in;
      pix_s2_q <= pix_s1_q;
    end
  end

  assign use_ch3  = (mode_q == pcm_pkg::ModeMat4);
  assign ctl.en   = en;
  assign ctl.mode = mode_q;

  for (genvar l = 0; l < pcm_pkg::NumCh; l++) begin : g_lane
    pcm_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (en),
      .ch_i      (pix_in.ch),
      .use_ch3_i (use_ch3),
      .row_i     (row_q[l]),
      .res_o     (lane_res[l])
    );
  end

  pcm_merge u_merge (
    .clk_i  (clk_i),
    .ctl_i  (ctl),
    .lane_i (lane_res),
    .pix_i  (pix_s2_q),
    .pix_o  (pix_out)
  );

  assign out_valid_o = vld_q[2];
  assign out_ch0_o   = pix_out.ch[0];
  assign out_ch1_o   = pix_out.ch[1];
  assign out_ch2_o   = pix_out.ch[2];
  assign out_ch3_o   = pix_out.ch[3];
  assign out_last_o  = pix_out.last;

endmodule

// ===== verif/pcm_color_board.sv =====
// color_board_pkg: expected-pixel store and color matrix predictor for the testbench
// depends on pcm_pkg for widths, mode codes, register indexes and the pixel type
package color_board_pkg;

  import pcm_pkg::*;

  localparam int ByteMax = (1 << ChW) - 1;

  class color_matrix_board;
    logic [ModeW-1:0] mode;
    logic [RowW-1:0]  rows [NumCh];
    pix_t             pending [$];
    int unsigned      mismatches;

    function new();
      mode       = ModePass;
      rows[0]    = RowRst0;
      rows[1]    = RowRst1;
      rows[2]    = RowRst2;
      rows[3]    = RowRst3;
      mismatches = 0;
    endfunction

    // mirror of the register file; indexes past the last row are dropped
    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      if (idx == CfgMode) begin
        mode = data[ModeW-1:0];
      end else if (idx >= CfgRow0 && idx <= CfgRow3) begin
        rows[idx - CfgRow0] = data;
      end
    endfunction

    // exact dot product, fraction dropped toward minus infinity, clamped to a byte
    function byte_t dot_floor_sat(logic [RowW-1:0] row, pix_t px, int unsigned cols);
      int                      acc;
      int unsigned             c;
      logic signed [CoefW-1:0] k;
      acc = 0;
      for (c = 0; c < cols; c++) begin
        k = row[CoefW*c +: CoefW];
        acc += int'(px.ch[c]) * int'(k);
      end
      if (acc < 0) return '0;
      acc = acc >>> FracW;
      if (acc > ByteMax) return byte_t'(ByteMax);
      return byte_t'(acc);
    endfunction

    function pix_t convert(pix_t px);
      pix_t        res;
      int unsigned i;
      res = px;
      if (mode == ModeMat3) begin
        for (i = 0; i < 3; i++) res.ch[i] = dot_floor_sat(rows[i], px, 3);
      end else if (mode == ModeMat4) begin
        for (i = 0; i < NumCh; i++) res.ch[i] = dot_floor_sat(rows[i], px, NumCh);
      end
      return res;
    endfunction

    function void note_pixel(pix_t px);
      pending.push_back(convert(px));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%t mismatch: %s", $realtime, msg);
    endfunction

    function void check_pixel(pix_t got);
      pix_t        want;
      int unsigned i;
      if (pending.size() == 0) begin
        report($sformatf("result beat with nothing pending (ch %h last %b)",
                         got.ch, got.last));
        return;
      end
      want = pending.pop_front();
      for (i = 0; i < NumCh; i++) begin
        if (got.ch[i] !== want.ch[i]) begin
          report($sformatf("out_ch%0d expected %02h, got %02h", i, want.ch[i], got.ch[i]));
        end
      end
      if (got.last !== want.last) begin
        report($sformatf("out_last expected %b, got %b", want.last, got.last));
      end
    endfunction
  endclass

endpackage

// ===== verif/tb_pixel_color_matrix_top.sv =====
// tb_pixel_color_matrix_top: directed and random pixel traffic through the color matrix,
// with random sender bursts, receiver stalls and register changes between phases
// depends on pcm_pkg, color_board_pkg and pixel_color_matrix_top
module tb_pixel_color_matrix_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcm_pkg::*;
  import color_board_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  // pipeline drain plus margin
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned RandomPixels  = 1530;
  localparam logic [ModeW-1:0] ModeSpare = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpare5 = CfgRow3 + 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpare7 = CfgRow3 + 3'd3;

  typedef enum int {StallNone, StallLight, StallHeavy, StallBeat} stall_e;
  typedef enum int {RowRandom, RowColor, RowCorner} row_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [7:0]          in_ch0_i, in_ch1_i, in_ch2_i, in_ch3_i;
  logic                in_last_i;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [7:0]          out_ch0_o, out_ch1_o, out_ch2_o, out_ch3_o;
  logic                out_last_o;

  color_matrix_board   board;
  pix_t                seen_in, seen_out;
  int unsigned         idle_cycles = 0;
  int unsigned         stall_tick = 0;
  stall_e              stall_kind = StallNone;
  int unsigned         sent;

  pixel_color_matrix_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_ch0_i    (in_ch0_i),
    .in_ch1_i    (in_ch1_i),
    .in_ch2_i    (in_ch2_i),
    .in_ch3_i    (in_ch3_i),
    .in_last_i   (in_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_ch0_o   (out_ch0_o),
    .out_ch1_o   (out_ch1_o),
    .out_ch2_o   (out_ch2_o),
    .out_ch3_o   (out_ch3_o),
    .out_last_o  (out_last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // receiver stall pattern, picked at random among none, light, heavy and beat
  always @(negedge clk_i) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_kind = stall_e'($urandom_range(0, 3));
    case (stall_kind)
      StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
      StallHeavy: out_stall_i <= ($urandom_range(0, 9) < 7);
      StallBeat:  out_stall_i <= (stall_tick % 5 < 2);
      default:    out_stall_i <= 1'b0;
    endcase
  end

  // results are checked before the same edge's input beat is noted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen_out.ch[0] = out_ch0_o;
        seen_out.ch[1] = out_ch1_o;
        seen_out.ch[2] = out_ch2_o;
        seen_out.ch[3] = out_ch3_o;
        seen_out.last  = out_last_o;
        board.check_pixel(seen_out);
      end
      if (in_valid_i && !in_stall_o) begin
        seen_in.ch[0] = in_ch0_i;
        seen_in.ch[1] = in_ch1_i;
        seen_in.ch[2] = in_ch2_i;
        seen_in.ch[3] = in_ch3_i;
        seen_in.last  = in_last_i;
        board.note_pixel(seen_in);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_pixel_color_matrix_top: done, errors");
      $finish;
    end
  end

  function automatic pix_t mk_pixel(byte_t c0, byte_t c1, byte_t c2, byte_t c3, logic last);
    pix_t p;
    p.ch[0] = c0;
    p.ch[1] = c1;
    p.ch[2] = c2;
    p.ch[3] = c3;
    p.last  = last;
    return p;
  endfunction

  function automatic byte_t random_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom_range(0, ByteMax));
    endcase
  endfunction

  function automatic pix_t random_pixel();
    return mk_pixel(random_byte(), random_byte(), random_byte(), random_byte(),
                    ($urandom_range(0, 7) == 0));
  endfunction

  function automatic logic [CoefW-1:0] pick_coef(row_e kind);
    logic [31:0] v;
    case (kind)
      RowColor: begin
        // typical conversion weights, within +-1.5
        v = $urandom_range(0, 'h3000) - 'h1800;
        return v[CoefW-1:0];
      end
      RowCorner: begin
        case ($urandom_range(0, 4))
          0:       return 16'h7FFF;
          1:       return 16'h8000;
          2:       return 16'h0000;
          3:       return 16'h1000;
          default: return 16'hFFFF;
        endcase
      end
      default: return CoefW'($urandom);
    endcase
  endfunction

  task automatic drive_pixel(input pix_t px);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_ch0_i   <= px.ch[0];
    in_ch1_i   <= px.ch[1];
    in_ch2_i   <= px.ch[2];
    in_ch3_i   <= px.ch[3];
    in_last_i  <= px.last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  // stop sending and wait for every expected pixel to come out
  task automatic settle();
    pause_sender(1);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    board.write_reg(idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_mode(input logic [ModeW-1:0] m);
    logic [CfgW-1:0] data;
    data = {$urandom, $urandom};
    data[ModeW-1:0] = m;
    write_reg(CfgMode, data);
  endtask

  task automatic random_setup();
    logic [RowW-1:0]  row;
    logic [CfgIdxW-1:0] idx;
    row_e             kind;
    int unsigned      r, c, pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) write_mode(ModePass);
    else if (pick == 1) write_mode(ModeSpare);
    else if (pick < 6) write_mode(ModeMat3);
    else write_mode(ModeMat4);
    for (r = 0; r < NumCh; r++) begin
      if ($urandom_range(0, 3) != 0) begin
        kind = row_e'($urandom_range(0, 2));
        for (c = 0; c < NumCh; c++) row[CoefW*c +: CoefW] = pick_coef(kind);
        write_reg(CfgIdxW'(CfgRow0 + r), row);
      end
    end
    if ($urandom_range(0, 4) == 0) begin
      idx = CfgIdxW'($urandom_range(CfgSpare5, CfgSpare7));
      write_reg(idx, {$urandom, $urandom});
    end
    end_writes();
  endtask

  task automatic send_stream(input int unsigned count);
    int unsigned burst;
    bit          gappy;
    gappy = ($urandom_range(0, 3) != 0);
    burst = $urandom_range(1, 24);
    repeat (count) begin
      drive_pixel(random_pixel());
      burst--;
      if (burst == 0) begin
        if (gappy) pause_sender($urandom_range(1, 8));
        burst = $urandom_range(1, 24);
      end
    end
  endtask

  initial begin
    int unsigned count;
    board       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CfgMode;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_ch0_i    = '0;
    in_ch1_i    = '0;
    in_ch2_i    = '0;
    in_ch3_i    = '0;
    in_last_i   = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset state: pass-through with the identity matrix
    drive_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    drive_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    drive_pixel(mk_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0));
    settle();

    // 3x3: cancelling weights, half weights, sum of 256, column 3 and row 3 ignored
    write_mode(ModeMat3);
    write_reg(CfgRow0, 64'h7FFF_0000_F000_1000);
    write_reg(CfgRow1, 64'h8000_0000_1000_1000);
    write_reg(CfgRow2, 64'h0000_0800_0000_0000);
    write_reg(CfgRow3, {4{16'h7FFF}});
    end_writes();
    drive_pixel(mk_pixel(8'h10, 8'h10, 8'h03, 8'hC3, 1'b0));
    drive_pixel(mk_pixel(8'h11, 8'h10, 8'hFF, 8'h00, 1'b1));
    drive_pixel(mk_pixel(8'h80, 8'h80, 8'h01, 8'h7E, 1'b0));
    drive_pixel(mk_pixel(8'h7F, 8'h80, 8'hFF, 8'hFF, 1'b0));
    settle();

    // 4x4 with the largest and the most negative coefficients
    write_mode(ModeMat4);
    end_writes();
    drive_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b0));
    drive_pixel(mk_pixel(8'h01, 8'h00, 8'h00, 8'h00, 1'b0));
    drive_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1));
    settle();
    write_reg(CfgRow0, {4{16'h8000}});
    write_reg(CfgRow1, {4{16'h8000}});
    write_reg(CfgRow2, {4{16'h8000}});
    write_reg(CfgRow3, {4{16'h8000}});
    end_writes();
    drive_pixel(mk_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0));
    drive_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h00, 1'b1));
    settle();
    // a sum just below zero
    write_reg(CfgRow0, 64'hFFFF_0000_0000_0000);
    write_reg(CfgRow3, RowRst3);
    end_writes();
    drive_pixel(mk_pixel(8'h00, 8'h00, 8'h00, 8'h01, 1'b0));
    settle();

    // writes past the last register must leave the matrix alone
    write_reg(CfgSpare5, '1);
    write_reg(CfgSpare5 + 3'd1, '1);
    write_reg(CfgSpare7, '1);
    end_writes();
    drive_pixel(mk_pixel(8'h40, 8'h80, 8'hC0, 8'hFF, 1'b0));
    drive_pixel(mk_pixel(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b1));
    settle();

    // unused mode code falls back to pass-through
    write_mode(ModeSpare);
    end_writes();
    drive_pixel(mk_pixel(8'h12, 8'h34, 8'h56, 8'h78, 1'b0));
    drive_pixel(mk_pixel(8'hFE, 8'h01, 8'h80, 8'h7F, 1'b1));
    settle();
    write_mode(ModePass);
    end_writes();
    drive_pixel(mk_pixel(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0));
    settle();

    sent = 0;
    while (sent < RandomPixels) begin
      random_setup();
      count = $urandom_range(40, 200);
      if (count > RandomPixels - sent) count = RandomPixels - sent;
      send_stream(count);
      sent += count;
      settle();
    end

    if (board.mismatches == 0) begin
      $display("tb_pixel_color_matrix_top: done, clean");
    end else begin
      $display("tb_pixel_color_matrix_top: done, errors");
    end
    $finish;
  end

endmodule
